// ===== design/spd_pkg.sv =====
// spd_pkg: shared types, codes and constants of the serial packet deframer
// no dependencies; imported by every module of the block
package spd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PID_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // 8 header bytes, 2 reserved check bytes, 2 trailer bytes
  localparam int unsigned FRAME_OVERHEAD = 12;

  // depth of the classified-word queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST     = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND    = 8'h55;
  localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'hFF;

  localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST      = 8'd1;
  localparam logic [LEN_W-1:0]  MAX_FRAME_LENGTH_RST = 9'd252;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LENGTH = 1'b1;

  // header byte positions within a frame
  localparam logic [LEN_W-1:0] OFS_SYNC_SECOND = 9'd1;
  localparam logic [LEN_W-1:0] OFS_DESTINATION = 9'd2;
  localparam logic [LEN_W-1:0] OFS_SOURCE      = 9'd3;
  localparam logic [LEN_W-1:0] OFS_PID_HIGH    = 9'd4;
  localparam logic [LEN_W-1:0] OFS_PID_LOW     = 9'd5;
  localparam logic [LEN_W-1:0] OFS_COMMAND     = 9'd6;
  localparam logic [LEN_W-1:0] OFS_DATA_LENGTH = 9'd7;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_IGNORED        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IN_FRAME       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FRAME_OK       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HEADER_MISMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERSIZE       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_TRAILER    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_ADDRESSED  = 3'd6;

  // classified word from front to back; a frame end with a good trailer
  // carries ST_FRAME_OK and the back applies the address filter
  typedef struct packed {
    logic [BYTE_W-1:0]   rx_byte;
    logic [LEN_W-1:0]    offset;
    logic [STATUS_W-1:0] status;
  } spd_word_t;

endpackage

// ===== design/serial_packet_deframer.sv =====
// serial_packet_deframer: top level of the sync-header, length-framed deframer
// depends on spd_pkg, spd_front, spd_queue, spd_back
//
// every received word yields exactly one result word: the byte echoed with its
// offset in the frame and a status (ignored, in frame, frame ok, header
// mismatch, oversize, bad trailer, not addressed). the block hunts for AA 55,
// reads destination, source, big-endian packet id, command and data length,
// and ends the frame after data length + 12 bytes; on a good frame the header
// fields and total length ride along with the last byte, otherwise they read
// zero. one word is accepted per clock, sustained, as long as results are
// popped; an accepted word is written into a queue slot, then moves into the
// result register, where it is on the result ports and can be popped. that
// rate is set by the front's per-byte compare-and-count step, which updates
// its state in the cycle of acceptance.
// the front classifies bytes into a QUEUE_DEPTH deep queue; the back captures
// header fields, applies the address filter and holds the result. registers:
// index 0 own_address (reset 1), index 1 max_frame_length (reset 252); write
// them only while no result is pending.
module serial_packet_deframer #(
  parameter int unsigned QUEUE_DEPTH = spd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input word channel
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [spd_pkg::BYTE_W-1:0]      in_rx_byte,
  // result word channel
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [spd_pkg::BYTE_W-1:0]      out_byte,
  output logic [spd_pkg::LEN_W-1:0]       out_byte_offset,
  output logic [spd_pkg::STATUS_W-1:0]    out_status,
  output logic [spd_pkg::BYTE_W-1:0]      out_frame_destination,
  output logic [spd_pkg::BYTE_W-1:0]      out_frame_source,
  output logic [spd_pkg::PID_W-1:0]       out_frame_packet_id,
  output logic [spd_pkg::BYTE_W-1:0]      out_frame_command,
  output logic [spd_pkg::BYTE_W-1:0]      out_frame_data_length,
  output logic [spd_pkg::LEN_W-1:0]       out_frame_length,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spd_pkg::LEN_W-1:0]       cfg_data
);
  import spd_pkg::*;

  logic [BYTE_W-1:0] own_address_r;
  logic [LEN_W-1:0]  max_frame_length_r;

  logic      in_accept;
  spd_word_t front_word;
  spd_word_t q_word;
  logic      q_empty;
  logic      q_pop;

  assign in_accept = in_push && !in_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r      <= OWN_ADDRESS_RST;
      max_frame_length_r <= MAX_FRAME_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDRESS:      own_address_r      <= cfg_data[BYTE_W-1:0];
        CFG_MAX_FRAME_LENGTH: max_frame_length_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: hunt, count and check each byte as it is accepted
  spd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (in_accept),
    .rx_byte          (in_rx_byte),
    .max_frame_length (max_frame_length_r),
    .word             (front_word)
  );

  // queue decouples the front from the result side
  spd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_word (front_word),
    .full      (in_full),
    .pop       (q_pop),
    .pop_word  (q_word),
    .empty     (q_empty)
  );

  // back: field capture, address filter, result register
  spd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_word                (q_word),
    .q_pop                 (q_pop),
    .own_address           (own_address_r),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_byte              (out_byte),
    .out_byte_offset       (out_byte_offset),
    .out_status            (out_status),
    .out_frame_destination (out_frame_destination),
    .out_frame_source      (out_frame_source),
    .out_frame_packet_id   (out_frame_packet_id),
    .out_frame_command     (out_frame_command),
    .out_frame_data_length (out_frame_data_length),
    .out_frame_length      (out_frame_length)
  );

  // a good frame ends on the trailer byte and its length follows its offset
  a_frame_ok_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_FRAME_OK) |->
      (out_byte == SYNC_FIRST && out_frame_length == out_byte_offset + LEN_W'(1)))
    else $error("good frame result has wrong trailer byte or length");

  // header fields are only reported with a good frame
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_FRAME_OK) |->
      (out_frame_length == '0 && out_frame_destination == '0 && out_frame_packet_id == '0))
    else $error("header fields reported on a frame that is not good");

  // bytes outside a frame sit at offset zero
  a_ignored_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ST_IGNORED) |-> (out_byte_offset == '0))
    else $error("ignored byte carries a nonzero offset");

  // a stalled result stays put until it is popped
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_byte) && $stable(out_status)))
    else $error("pending result changed before it was popped");

endmodule

// ===== design/spd_front.sv =====
// spd_front: sync hunt, byte counting, length and trailer checks per byte
// depends on spd_pkg
module spd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [spd_pkg::BYTE_W-1:0] rx_byte,
  input  logic [spd_pkg::LEN_W-1:0]  max_frame_length,
  output spd_pkg::spd_word_t         word
);
  import spd_pkg::*;

  typedef enum logic [1:0] {
    WAIT_FIRST,
    WAIT_SECOND,
    IN_FRAME
  } state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [LEN_W-1:0]  expected_r, expected_nxt;
  logic [BYTE_W-1:0] prev_r;
  logic [LEN_W-1:0]  count_inc;
  logic [LEN_W-1:0]  length_calc;

  assign count_inc   = count_r + LEN_W'(1);
  assign length_calc = LEN_W'(rx_byte) + LEN_W'(FRAME_OVERHEAD);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    expected_nxt = expected_r;
    word.rx_byte = rx_byte;
    word.offset  = '0;
    word.status  = ST_IGNORED;
    case (state_r)
      WAIT_FIRST: begin
        if (rx_byte == SYNC_FIRST) begin
          state_nxt   = WAIT_SECOND;
          count_nxt   = LEN_W'(1);
          word.status = ST_IN_FRAME;
        end
      end
      WAIT_SECOND: begin
        word.offset = OFS_SYNC_SECOND;
        if (rx_byte == SYNC_SECOND) begin
          state_nxt   = IN_FRAME;
          count_nxt   = OFS_DESTINATION;
          word.status = ST_IN_FRAME;
        end else begin
          state_nxt   = WAIT_FIRST;
          count_nxt   = '0;
          word.status = ST_HEADER_MISMATCH;
        end
      end
      IN_FRAME: begin
        word.offset = count_r;
        word.status = ST_IN_FRAME;
        count_nxt   = count_inc;
        if (count_r == OFS_DATA_LENGTH) begin
          expected_nxt = length_calc;
          if (length_calc > max_frame_length) begin
            word.status = ST_OVERSIZE;
            state_nxt   = WAIT_FIRST;
            count_nxt   = '0;
          end
        end else if (count_inc >= LEN_W'(FRAME_OVERHEAD) && count_inc >= expected_r) begin
          // last byte of the frame: trailer must read 55 AA
          if (prev_r == SYNC_SECOND && rx_byte == SYNC_FIRST) begin
            word.status = ST_FRAME_OK;
          end else begin
            word.status = ST_BAD_TRAILER;
          end
          state_nxt = WAIT_FIRST;
          count_nxt = '0;
        end
      end
      default: begin
        state_nxt = WAIT_FIRST;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= WAIT_FIRST;
      count_r    <= '0;
      expected_r <= '0;
      prev_r     <= '0;
    end else if (accept) begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      expected_r <= expected_nxt;
      prev_r     <= rx_byte;
    end
  end

endmodule

// ===== design/spd_queue.sv =====
// spd_queue: short first-in first-out queue of classified words
// depends on spd_pkg
module spd_queue #(
  parameter int unsigned DEPTH = spd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  spd_pkg::spd_word_t push_word,
  output logic               full,
  input  logic               pop,
  output spd_pkg::spd_word_t pop_word,
  output logic               empty
);
  import spd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  spd_word_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/spd_back.sv =====
// spd_back: header field capture, address filter and result register
// depends on spd_pkg
module spd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  spd_pkg::spd_word_t           q_word,
  output logic                         q_pop,
  input  logic [spd_pkg::BYTE_W-1:0]   own_address,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [spd_pkg::BYTE_W-1:0]   out_byte,
  output logic [spd_pkg::LEN_W-1:0]    out_byte_offset,
  output logic [spd_pkg::STATUS_W-1:0] out_status,
  output logic [spd_pkg::BYTE_W-1:0]   out_frame_destination,
  output logic [spd_pkg::BYTE_W-1:0]   out_frame_source,
  output logic [spd_pkg::PID_W-1:0]    out_frame_packet_id,
  output logic [spd_pkg::BYTE_W-1:0]   out_frame_command,
  output logic [spd_pkg::BYTE_W-1:0]   out_frame_data_length,
  output logic [spd_pkg::LEN_W-1:0]    out_frame_length
);
  import spd_pkg::*;

  logic                out_valid_r;
  logic [BYTE_W-1:0]   dest_r, src_r, cmd_r, dlen_r;
  logic [PID_W-1:0]    pid_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [LEN_W-1:0]    offset_r, flen_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [BYTE_W-1:0]   f_dest_r, f_src_r, f_cmd_r, f_dlen_r;
  logic [PID_W-1:0]    f_pid_r;
  logic                capture, frame_ok;

  assign q_pop   = !q_empty && (!out_valid_r || out_pop);
  assign capture = (q_word.status == ST_IN_FRAME) || (q_word.status == ST_OVERSIZE);

  always_comb begin
    status_nxt = q_word.status;
    if (q_word.status == ST_FRAME_OK && dest_r != own_address && dest_r != BROADCAST_ADDR) begin
      status_nxt = ST_NOT_ADDRESSED;
    end
  end
  assign frame_ok = (status_nxt == ST_FRAME_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= '0;
      src_r  <= '0;
      pid_r  <= '0;
      cmd_r  <= '0;
      dlen_r <= '0;
    end else if (q_pop && capture) begin
      case (q_word.offset)
        OFS_DESTINATION: dest_r <= q_word.rx_byte;
        OFS_SOURCE:      src_r  <= q_word.rx_byte;
        OFS_PID_HIGH:    pid_r  <= {q_word.rx_byte, pid_r[BYTE_W-1:0]};
        OFS_PID_LOW:     pid_r  <= {pid_r[PID_W-1:BYTE_W], q_word.rx_byte};
        OFS_COMMAND:     cmd_r  <= q_word.rx_byte;
        OFS_DATA_LENGTH: dlen_r <= q_word.rx_byte;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_r   <= q_word.rx_byte;
      offset_r <= q_word.offset;
      status_r <= status_nxt;
      f_dest_r <= frame_ok ? dest_r : '0;
      f_src_r  <= frame_ok ? src_r : '0;
      f_pid_r  <= frame_ok ? pid_r : '0;
      f_cmd_r  <= frame_ok ? cmd_r : '0;
      f_dlen_r <= frame_ok ? dlen_r : '0;
      flen_r   <= frame_ok ? q_word.offset + LEN_W'(1) : '0;
    end
  end

  assign out_empty             = !out_valid_r;
  assign out_byte              = byte_r;
  assign out_byte_offset       = offset_r;
  assign out_status            = status_r;
  assign out_frame_destination = f_dest_r;
  assign out_frame_source      = f_src_r;
  assign out_frame_packet_id   = f_pid_r;
  assign out_frame_command     = f_cmd_r;
  assign out_frame_data_length = f_dlen_r;
  assign out_frame_length      = flen_r;

endmodule

// ===== sim/spd_checker.sv =====
// spd_checker: predicts every result word of the serial packet deframer and checks it
// depends on spd_pkg; watches the input, result and configuration ports of the block
`timescale 1ns / 1ps

module spd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  logic [spd_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  logic [spd_pkg::BYTE_W-1:0]    out_byte,
  input  logic [spd_pkg::LEN_W-1:0]     out_byte_offset,
  input  logic [spd_pkg::STATUS_W-1:0]  out_status,
  input  logic [spd_pkg::BYTE_W-1:0]    out_frame_destination,
  input  logic [spd_pkg::BYTE_W-1:0]    out_frame_source,
  input  logic [spd_pkg::PID_W-1:0]     out_frame_packet_id,
  input  logic [spd_pkg::BYTE_W-1:0]    out_frame_command,
  input  logic [spd_pkg::BYTE_W-1:0]    out_frame_data_length,
  input  logic [spd_pkg::LEN_W-1:0]     out_frame_length,
  input  logic                          cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spd_pkg::LEN_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending_words,
  output int                            words_checked,
  output int                            frames_ok
);
  import spd_pkg::*;

  typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, IN_BODY} seek_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   echo;
    logic [LEN_W-1:0]    offset;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   dest;
    logic [BYTE_W-1:0]   src;
    logic [PID_W-1:0]    pid;
    logic [BYTE_W-1:0]   cmd;
    logic [BYTE_W-1:0]   dlen;
    logic [LEN_W-1:0]    flen;
  } deframed_t;

  deframed_t expected_words[$];

  // predictor state and register copies
  seek_t             seek;
  logic [LEN_W-1:0]  body_count;
  logic [LEN_W-1:0]  target_len;
  logic [BYTE_W-1:0] last_byte;
  logic [BYTE_W-1:0] hdr_dest;
  logic [BYTE_W-1:0] hdr_src;
  logic [PID_W-1:0]  hdr_pid;
  logic [BYTE_W-1:0] hdr_cmd;
  logic [BYTE_W-1:0] hdr_dlen;
  logic [BYTE_W-1:0] own_addr;
  logic [LEN_W-1:0]  max_len;

  function automatic deframed_t deframe(input logic [BYTE_W-1:0] b);
    deframed_t         r;
    logic [LEN_W-1:0]  ofs;
    logic [STATUS_W-1:0] st;
    logic              good;
    r = '0;
    ofs = '0;
    st = ST_IGNORED;
    good = 1'b0;
    case (seek)
      SEEK_FIRST: begin
        if (b == SYNC_FIRST) begin
          seek = SEEK_SECOND;
          body_count = 9'd1;
          st = ST_IN_FRAME;
        end
      end
      SEEK_SECOND: begin
        ofs = OFS_SYNC_SECOND;
        if (b == SYNC_SECOND) begin
          seek = IN_BODY;
          body_count = 9'd2;
          st = ST_IN_FRAME;
        end else begin
          st = ST_HEADER_MISMATCH;
          seek = SEEK_FIRST;
          body_count = '0;
        end
      end
      default: begin
        ofs = body_count;
        st = ST_IN_FRAME;
        case (ofs)
          OFS_DESTINATION: hdr_dest = b;
          OFS_SOURCE:      hdr_src = b;
          OFS_PID_HIGH:    hdr_pid[15:8] = b;
          OFS_PID_LOW:     hdr_pid[7:0] = b;
          OFS_COMMAND:     hdr_cmd = b;
          OFS_DATA_LENGTH: hdr_dlen = b;
          default: ;
        endcase
        body_count = body_count + 9'd1;
        if (ofs == OFS_DATA_LENGTH) begin
          target_len = {1'b0, b} + LEN_W'(FRAME_OVERHEAD);
          if (target_len > max_len) begin
            st = ST_OVERSIZE;
            seek = SEEK_FIRST;
            body_count = '0;
          end
        end
        if (seek == IN_BODY && body_count >= LEN_W'(FRAME_OVERHEAD) &&
            body_count >= target_len) begin
          // trailer first, then the address filter
          if (last_byte != SYNC_SECOND || b != SYNC_FIRST)
            st = ST_BAD_TRAILER;
          else if (hdr_dest != own_addr && hdr_dest != BROADCAST_ADDR)
            st = ST_NOT_ADDRESSED;
          else begin
            st = ST_FRAME_OK;
            good = 1'b1;
          end
          if (good) begin
            r.dest = hdr_dest;
            r.src  = hdr_src;
            r.pid  = hdr_pid;
            r.cmd  = hdr_cmd;
            r.dlen = hdr_dlen;
            r.flen = body_count;
          end
          seek = SEEK_FIRST;
          body_count = '0;
        end
      end
    endcase
    last_byte = b;
    r.echo = b;
    r.offset = ofs;
    r.status = st;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    deframed_t want;
    if (!rst_n) begin
      seek = SEEK_FIRST;
      body_count = '0;
      target_len = '0;
      last_byte = '0;
      hdr_dest = '0;
      hdr_src = '0;
      hdr_pid = '0;
      hdr_cmd = '0;
      hdr_dlen = '0;
      own_addr = OWN_ADDRESS_RST;
      max_len = MAX_FRAME_LENGTH_RST;
      expected_words.delete();
    end else begin
      // compare the popped word first, then record the newly pushed one
      if (out_pop && !out_empty) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          fail_count++;
          $error("result word with nothing expected: byte %0h status %0d",
                 out_byte, out_status);
        end else begin
          want = expected_words.pop_front();
          check_field("out_byte", want.echo, out_byte);
          check_field("out_byte_offset", want.offset, out_byte_offset);
          check_field("out_status", want.status, out_status);
          check_field("out_frame_destination", want.dest, out_frame_destination);
          check_field("out_frame_source", want.src, out_frame_source);
          check_field("out_frame_packet_id", want.pid, out_frame_packet_id);
          check_field("out_frame_command", want.cmd, out_frame_command);
          check_field("out_frame_data_length", want.dlen, out_frame_data_length);
          check_field("out_frame_length", want.flen, out_frame_length);
          if (want.status == ST_FRAME_OK)
            frames_ok++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ADDRESS:      own_addr = cfg_data[BYTE_W-1:0];
          CFG_MAX_FRAME_LENGTH: max_len = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        expected_words.push_back(deframe(in_rx_byte));
    end
    pending_words = expected_words.size();
  end

endmodule

// ===== sim/serial_packet_deframer_tb.sv =====
// serial_packet_deframer_tb: stimulus, flow control and verdict for the deframer
// depends on spd_pkg, spd_checker and the serial_packet_deframer design
`timescale 1ns / 1ps

module serial_packet_deframer_tb;
  import spd_pkg::*;

  // generous bound, far above the slowest correct run
  localparam int LIMIT_CYCLES = 400000;
  // receiver hold-off long enough to fill the block and stall its input
  localparam int LONG_HOLD    = 100;
  // words of random traffic per register setting / flow-control mix
  localparam int PHASE_WORDS  = 100;
  localparam int NUM_PHASES   = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_empty;
  logic                 out_pop;
  logic [BYTE_W-1:0]    out_byte;
  logic [LEN_W-1:0]     out_byte_offset;
  logic [STATUS_W-1:0]  out_status;
  logic [BYTE_W-1:0]    out_frame_destination;
  logic [BYTE_W-1:0]    out_frame_source;
  logic [PID_W-1:0]     out_frame_packet_id;
  logic [BYTE_W-1:0]    out_frame_command;
  logic [BYTE_W-1:0]    out_frame_data_length;
  logic [LEN_W-1:0]     out_frame_length;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_data;

  int fail_count;
  int pending_words;
  int words_checked;
  int frames_ok;

  int words_sent  = 0;
  int cycle_count = 0;
  // flow-control knobs, percent of cycles
  int idle_pct    = 0;
  int stall_pct   = 0;
  // long hold-off handshake between stimulus and receiver
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;

  serial_packet_deframer DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_rx_byte            (in_rx_byte),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_byte              (out_byte),
    .out_byte_offset       (out_byte_offset),
    .out_status            (out_status),
    .out_frame_destination (out_frame_destination),
    .out_frame_source      (out_frame_source),
    .out_frame_packet_id   (out_frame_packet_id),
    .out_frame_command     (out_frame_command),
    .out_frame_data_length (out_frame_data_length),
    .out_frame_length      (out_frame_length),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  spd_checker result_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_rx_byte            (in_rx_byte),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_byte              (out_byte),
    .out_byte_offset       (out_byte_offset),
    .out_status            (out_status),
    .out_frame_destination (out_frame_destination),
    .out_frame_source      (out_frame_source),
    .out_frame_packet_id   (out_frame_packet_id),
    .out_frame_command     (out_frame_command),
    .out_frame_data_length (out_frame_data_length),
    .out_frame_length      (out_frame_length),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .fail_count            (fail_count),
    .pending_words         (pending_words),
    .words_checked         (words_checked),
    .frames_ok             (frames_ok)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, pending_words);
      $display("serial_packet_deframer verification failed");
      $finish;
    end
  end

  // receiver: random pops, plus one long hold-off counted here
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      out_pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one word, with random idle cycles ahead of it; entered and left at a
  // falling edge, and push stays high straight into the next word when no gap
  task automatic send_word(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // whole frame: sync, header, payload plus the two check bytes, trailer
  task automatic send_frame(input logic [BYTE_W-1:0] dest, input logic [BYTE_W-1:0] src,
                            input logic [PID_W-1:0] pid, input logic [BYTE_W-1:0] cmd,
                            input logic [BYTE_W-1:0] dlen, input bit good_trailer);
    send_word(SYNC_FIRST);
    send_word(SYNC_SECOND);
    send_word(dest);
    send_word(src);
    send_word(pid[15:8]);
    send_word(pid[7:0]);
    send_word(cmd);
    send_word(dlen);
    repeat (int'(dlen) + 2) send_word(BYTE_W'($urandom));
    if (good_trailer) begin
      send_word(SYNC_SECOND);
      send_word(SYNC_FIRST);
    end else begin
      // half the time one trailer byte is right, so each byte is tested alone
      send_word($urandom_range(1) ? SYNC_SECOND : BYTE_W'($urandom));
      send_word($urandom_range(1) ? BYTE_W'($urandom) : SYNC_FIRST);
    end
  endtask

  // stop pushing and wait for every expected word, then a few more cycles
  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [BYTE_W-1:0] own;
    logic [LEN_W-1:0]  max_len;
    logic [BYTE_W-1:0] dest;
    logic [BYTE_W-1:0] dlen;
    int                phase_end;
    int                pick;

    rst_n = 1'b0;
    in_push = 1'b0;
    in_rx_byte = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_OWN_ADDRESS;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset register values (own address 1, limit 252)
    // bytes outside a frame are ignored, including a lone 55
    send_word(8'h00);
    send_word(8'hFF);
    send_word(SYNC_SECOND);
    // header mismatch, the 00 does not restart anything
    send_word(SYNC_FIRST);
    send_word(8'h00);
    // header mismatch on a second AA, which is not taken as a new sync
    send_word(SYNC_FIRST);
    send_word(SYNC_FIRST);
    // shortest legal frame to the own address
    send_frame(8'h01, 8'hFF, 16'h00FF, 8'h00, 8'd0, 1'b1);
    // data length 241 makes 253 bytes, one past the limit: dropped at offset 7
    send_word(SYNC_FIRST);
    send_word(SYNC_SECOND);
    send_word(8'hFF);
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'hFF);
    send_word(8'hFF);
    send_word(8'd241);

    // random part: one register setting and one flow-control mix per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: begin own = 8'h01; max_len = 9'd252; end
        1: begin own = 8'h00; max_len = 9'd12;  end
        2: begin own = 8'hFF; max_len = 9'd267; end
        3: begin own = 8'h5A; max_len = 9'd11;  end
        4: begin own = 8'h80; max_len = 9'd40;  end
        default: begin
          own = BYTE_W'($urandom);
          max_len = LEN_W'($urandom_range(12, 267));
        end
      endcase
      write_reg(CFG_OWN_ADDRESS, {1'b0, own});
      write_reg(CFG_MAX_FRAME_LENGTH, max_len);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      // long receiver hold-off while the sender keeps offering words
      if (p == 0)
        hold_request = 1'b1;
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // well-formed frame, random content
          case ($urandom_range(9))
            0, 1, 2, 3: dest = own;
            4, 5:       dest = BROADCAST_ADDR;
            default:    dest = BYTE_W'($urandom);
          endcase
          dlen = ($urandom_range(19) == 0) ? BYTE_W'($urandom) :
                                             BYTE_W'($urandom_range(0, 20));
          send_frame(dest, BYTE_W'($urandom), PID_W'($urandom), BYTE_W'($urandom),
                     dlen, $urandom_range(99) < 85);
        end else if (pick < 80) begin
          // broken sync
          send_word(SYNC_FIRST);
          send_word(BYTE_W'($urandom));
        end else if (pick < 90) begin
          // line noise
          repeat ($urandom_range(1, 4)) send_word(BYTE_W'($urandom));
        end else begin
          // frame cut short; following words land inside it
          send_word(SYNC_FIRST);
          send_word(SYNC_SECOND);
          repeat ($urandom_range(1, 6)) send_word(BYTE_W'($urandom));
        end
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    $display("%0d words pushed, %0d result words checked, %0d frames accepted",
             words_sent, words_checked, frames_ok);
    $display("%0d register settings, four flow-control mixes, one long receiver hold-off",
             NUM_PHASES);
    if (fail_count == 0 && pending_words == 0)
      $display("serial_packet_deframer verification clean");
    else
      $display("serial_packet_deframer verification failed");
    $finish;
  end

endmodule

// ===== serial_packet_deframer.f =====
design/spd_pkg.sv
design/spd_front.sv
design/spd_queue.sv
design/spd_back.sv
design/serial_packet_deframer.sv
sim/spd_checker.sv
sim/serial_packet_deframer_tb.sv
